FILE: src/segment_crossing_test_3d_defines.svh
// Assertion macros for the segment crossing test block.
// Used by the top level; no dependencies.
`ifndef SEGMENT_CROSSING_TEST_3D_DEFINES_SVH
`define SEGMENT_CROSSING_TEST_3D_DEFINES_SVH
`ifndef SYNTHESIS
`define SCX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define SCX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SCX_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SCX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/scx_pkg.sv
// Shared constants and types for the segment crossing test block.
// No dependencies.
package scx_pkg;

	localparam int COORD_BITS_DEF = 16;

	// closest point position against its own segment
	localparam logic [1:0] SIDE_ON     = 2'd0;
	localparam logic [1:0] SIDE_BEFORE = 2'd1;
	localparam logic [1:0] SIDE_BEYOND = 2'd2;

	// load enables for the two stages of a split multiplier
	typedef struct packed {
		logic mul;
		logic sum;
	} stage_en_t;

endpackage

FILE: src/scx_in_if.sv
// Input channel: one segment pair per item, valid/ready handshake.
// Depends on scx_pkg for the default coordinate width.
interface scx_in_if
	import scx_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_start_x;
	logic signed [COORD_BITS-1:0] a_start_y;
	logic signed [COORD_BITS-1:0] a_start_z;
	logic signed [COORD_BITS-1:0] a_end_x;
	logic signed [COORD_BITS-1:0] a_end_y;
	logic signed [COORD_BITS-1:0] a_end_z;
	logic signed [COORD_BITS-1:0] b_start_x;
	logic signed [COORD_BITS-1:0] b_start_y;
	logic signed [COORD_BITS-1:0] b_start_z;
	logic signed [COORD_BITS-1:0] b_end_x;
	logic signed [COORD_BITS-1:0] b_end_y;
	logic signed [COORD_BITS-1:0] b_end_z;

	modport source (
		output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
		       b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
		input  ready
	);
	modport sink (
		input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
		       b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
		output ready
	);
endinterface

FILE: src/scx_out_if.sv
// Output channel: one classification result per item, valid/ready handshake.
// No dependencies.
interface scx_out_if;
	logic       valid;
	logic       ready;
	logic       crossing;
	logic       parallel;
	logic [1:0] side_a;
	logic [1:0] side_b;

	modport source (
		output valid, crossing, parallel, side_a, side_b,
		input  ready
	);
	modport sink (
		input  valid, crossing, parallel, side_a, side_b,
		output ready
	);
endinterface

FILE: src/scx_wide_mul.sv
// Two-stage signed multiplier: four half-width partial products, then their sum.
// Depends on scx_pkg for the stage enable struct.
module scx_wide_mul
	import scx_pkg::*;
#(
	parameter int A_BITS = 2 * COORD_BITS_DEF + 3
) (
	input  logic                       clk,
	input  stage_en_t                  en,
	input  logic signed [A_BITS-1:0]   a,
	input  logic signed [A_BITS-1:0]   b,
	output logic signed [2*A_BITS-1:0] p
);

	localparam int H  = A_BITS / 2;
	localparam int HB = A_BITS - H;
	localparam int PW = 2 * A_BITS;

	logic [H-1:0]          a_lo, b_lo;
	logic signed [HB-1:0]  a_hi, b_hi;
	logic signed [H:0]     a_lo_s, b_lo_s;

	logic signed [2*HB-1:0] hh_s4;
	logic signed [HB+H:0]   hl_s4, lh_s4;
	logic [2*H-1:0]         ll_s4;

	logic signed [PW-1:0] hh_x, hl_x, lh_x, ll_x;

	assign a_lo   = a[H-1:0];
	assign b_lo   = b[H-1:0];
	assign a_hi   = a[A_BITS-1:H];
	assign b_hi   = b[A_BITS-1:H];
	assign a_lo_s = signed'({1'b0, a_lo});
	assign b_lo_s = signed'({1'b0, b_lo});

	always_ff @(posedge clk) begin
		if (en.mul) begin
			hh_s4 <= a_hi * b_hi;
			hl_s4 <= a_hi * b_lo_s;
			lh_s4 <= a_lo_s * b_hi;
			ll_s4 <= a_lo * b_lo;
		end
	end

	assign hh_x = PW'(hh_s4);
	assign hl_x = PW'(hl_s4);
	assign lh_x = PW'(lh_s4);
	assign ll_x = signed'(PW'(ll_s4));

	always_ff @(posedge clk) begin
		if (en.sum) begin
			p <= (hh_x <<< (2 * H)) + ((hl_x + lh_x) <<< H) + ll_x;
		end
	end

endmodule

FILE: src/segment_crossing_test_3d.sv
// An accepted item passes through the stage registers s1 to s7; s7 is the output register.
// Throughput: one item per cycle unless the output stalls; each stage holds one item and a bubble closes
// up under a stall, so input is taken while a finished result waits, as long as some stage is empty.
// The depth is set by the multiply and subtract levels of the cross products and the split
// wide multipliers of the dot products. Reset clears only the stage valid bits.
`include "segment_crossing_test_3d_defines.svh"
module segment_crossing_test_3d
	import scx_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	scx_in_if.sink        pair,
	scx_out_if.source     result
);

	localparam int DW = COORD_BITS + 1;  // coordinate differences
	localparam int CW = 2 * DW;          // cross product terms
	localparam int NW = CW + 1;          // cross product components
	localparam int PW = 2 * NW;          // dot product terms
	localparam int SW = PW + 2;          // dot product sums

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	stage_en_t mul_en;

	logic signed [COORD_BITS-1:0] a1 [3], a2 [3], b1 [3], b2 [3];

	logic signed [DW-1:0] dir_a_s1 [3], dir_b_s1 [3], ofs_s1 [3];
	logic signed [CW-1:0] nl_s2 [3], nr_s2 [3], vl_s2 [3], vr_s2 [3];
	logic signed [CW-1:0] ul_s2 [3], ur_s2 [3];
	logic signed [NW-1:0] n_s3 [3], qv_s3 [3], qu_s3 [3];
	logic signed [PW-1:0] dd_term [3], ns_term [3], nt_term [3];
	logic signed [SW-1:0] d_s6, ns_s6, nt_s6;

	logic       par_c;
	logic [1:0] side_a_c, side_b_c;

	logic       crossing_s7, parallel_s7;
	logic [1:0] side_a_s7, side_b_s7;

	function automatic logic [1:0] side_of(input logic signed [SW-1:0] num,
	                                       input logic signed [SW-1:0] den);
		logic signed [SW-1:0] diff;
		diff = den - num;
		priority if (num[SW-1] || (num == '0)) begin
			return SIDE_BEFORE;
		end else if (diff[SW-1]) begin
			return SIDE_BEYOND;
		end else begin
			return SIDE_ON;
		end
	endfunction

	// a stage loads when it is empty or its content moves on
	assign en_s7 = !vld_s7 || result.ready;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign pair.ready = en_s1;

	assign mul_en.mul = en_s4;
	assign mul_en.sum = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= pair.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	assign a1[0] = pair.a_start_x;
	assign a1[1] = pair.a_start_y;
	assign a1[2] = pair.a_start_z;
	assign a2[0] = pair.a_end_x;
	assign a2[1] = pair.a_end_y;
	assign a2[2] = pair.a_end_z;
	assign b1[0] = pair.b_start_x;
	assign b1[1] = pair.b_start_y;
	assign b1[2] = pair.b_start_z;
	assign b2[0] = pair.b_end_x;
	assign b2[1] = pair.b_end_y;
	assign b2[2] = pair.b_end_z;

	// direction vectors and start offset
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < 3; k++) begin
				dir_a_s1[k] <= DW'(a2[k]) - DW'(a1[k]);
				dir_b_s1[k] <= DW'(b2[k]) - DW'(b1[k]);
				ofs_s1[k]   <= DW'(b1[k]) - DW'(a1[k]);
			end
		end
	end

	// cross products: n = u x v, qv = q x v, qu = q x u
	for (genvar k = 0; k < 3; k++) begin : g_cross
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;

		always_ff @(posedge clk) begin
			if (en_s2) begin
				nl_s2[k] <= dir_a_s1[K1] * dir_b_s1[K2];
				nr_s2[k] <= dir_a_s1[K2] * dir_b_s1[K1];
				vl_s2[k] <= ofs_s1[K1] * dir_b_s1[K2];
				vr_s2[k] <= ofs_s1[K2] * dir_b_s1[K1];
				ul_s2[k] <= ofs_s1[K1] * dir_a_s1[K2];
				ur_s2[k] <= ofs_s1[K2] * dir_a_s1[K1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s3) begin
				n_s3[k]  <= NW'(nl_s2[k]) - NW'(nr_s2[k]);
				qv_s3[k] <= NW'(vl_s2[k]) - NW'(vr_s2[k]);
				qu_s3[k] <= NW'(ul_s2[k]) - NW'(ur_s2[k]);
			end
		end

		scx_wide_mul #(.A_BITS(NW)) u_mul_d (
			.clk (clk),
			.en  (mul_en),
			.a   (n_s3[k]),
			.b   (n_s3[k]),
			.p   (dd_term[k])
		);

		scx_wide_mul #(.A_BITS(NW)) u_mul_s (
			.clk (clk),
			.en  (mul_en),
			.a   (qv_s3[k]),
			.b   (n_s3[k]),
			.p   (ns_term[k])
		);

		scx_wide_mul #(.A_BITS(NW)) u_mul_t (
			.clk (clk),
			.en  (mul_en),
			.a   (qu_s3[k]),
			.b   (n_s3[k]),
			.p   (nt_term[k])
		);
	end

	// determinant and the two parameter numerators
	always_ff @(posedge clk) begin
		if (en_s6) begin
			d_s6  <= SW'(dd_term[0]) + SW'(dd_term[1]) + SW'(dd_term[2]);
			ns_s6 <= SW'(ns_term[0]) + SW'(ns_term[1]) + SW'(ns_term[2]);
			nt_s6 <= SW'(nt_term[0]) + SW'(nt_term[1]) + SW'(nt_term[2]);
		end
	end

	// classify; parallel lines force both sides to on-segment
	always_comb begin
		par_c = (d_s6 == '0);
		if (par_c) begin
			side_a_c = SIDE_ON;
			side_b_c = SIDE_ON;
		end else begin
			side_a_c = side_of(ns_s6, d_s6);
			side_b_c = side_of(nt_s6, d_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			crossing_s7 <= !par_c && (side_a_c == SIDE_ON) && (side_b_c == SIDE_ON);
			parallel_s7 <= par_c;
			side_a_s7   <= side_a_c;
			side_b_s7   <= side_b_c;
		end
	end

	assign result.valid    = vld_s7;
	assign result.crossing = crossing_s7;
	assign result.parallel = parallel_s7;
	assign result.side_a   = side_a_s7;
	assign result.side_b   = side_b_s7;

	`SCX_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, pair.valid && pair.ready, vld_s1)
	`SCX_ASSERT_SAME(a_parallel_clean, clk, arst_n, vld_s7 && parallel_s7, !crossing_s7 && (side_a_s7 == SIDE_ON) && (side_b_s7 == SIDE_ON))
	`SCX_ASSERT_SAME(a_crossing_sides, clk, arst_n, vld_s7 && crossing_s7, !parallel_s7 && (side_a_s7 == SIDE_ON) && (side_b_s7 == SIDE_ON))
	`SCX_ASSERT_NEXT(a_stall_keeps_s6, clk, arst_n, vld_s6 && vld_s7 && !result.ready, vld_s6)

endmodule

FILE: tb/segment_crossing_test_3d_tb.sv
// Self-checking bench for segment_crossing_test_3d: directed and random segment pairs
// go in, and each classification is checked against an exact integer predictor.
// Depends on scx_pkg, scx_in_if, scx_out_if and the block itself.
module segment_crossing_test_3d_tb;
	import scx_pkg::*;

	localparam int COORD_BITS  = COORD_BITS_DEF;
	localparam int WIDE_BITS   = 160;
	localparam int LATENCY     = 7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 100;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [WIDE_BITS-1:0]  wide_t;

	typedef struct packed {
		wide_t x;
		wide_t y;
		wide_t z;
	} vec_t;

	typedef struct packed {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_start_z;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t a_end_z;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_start_z;
		coord_t b_end_x;
		coord_t b_end_y;
		coord_t b_end_z;
	} seg_pair_t;

	typedef struct packed {
		logic       crossing;
		logic       parallel;
		logic [1:0] side_a;
		logic [1:0] side_b;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	scx_in_if #(.COORD_BITS(COORD_BITS)) pair_ch ();
	scx_out_if result_ch ();

	segment_crossing_test_3d #(.COORD_BITS(COORD_BITS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	verdict_t verdict_q[$];
	int       error_count    = 0;
	int       checked_count  = 0;
	int       crossing_count = 0;
	int       parallel_count = 0;
	int       sent_count     = 0;
	int       cycle_count    = 0;
	int       tx_idle_pct    = 0;
	int       rx_idle_pct    = 0;

	// ---------------------------------------------------------------- predictor

	function automatic vec_t cross_wide(input vec_t x, input vec_t y);
		vec_t r;
		r.x = x.y * y.z - x.z * y.y;
		r.y = x.z * y.x - x.x * y.z;
		r.z = x.x * y.y - x.y * y.x;
		return r;
	endfunction

	function automatic wide_t dot_wide(input vec_t x, input vec_t y);
		return x.x * y.x + x.y * y.y + x.z * y.z;
	endfunction

	// position of a closest point given its parameter as num / den, den > 0
	function automatic logic [1:0] side_of_param(input wide_t num, input wide_t den);
		if (num <= 0)
			return SIDE_BEFORE;
		if (num > den)
			return SIDE_BEYOND;
		return SIDE_ON;
	endfunction

	function automatic vec_t diff_vec(input coord_t hx, hy, hz, tx, ty, tz);
		vec_t r;
		r.x = wide_t'(hx) - wide_t'(tx);
		r.y = wide_t'(hy) - wide_t'(ty);
		r.z = wide_t'(hz) - wide_t'(tz);
		return r;
	endfunction

	function automatic verdict_t classify_pair(input seg_pair_t p);
		vec_t     dir_a, dir_b, gap, normal;
		wide_t    det, num_a, num_b;
		verdict_t r;
		dir_a  = diff_vec(p.a_end_x, p.a_end_y, p.a_end_z,
		                  p.a_start_x, p.a_start_y, p.a_start_z);
		dir_b  = diff_vec(p.b_end_x, p.b_end_y, p.b_end_z,
		                  p.b_start_x, p.b_start_y, p.b_start_z);
		gap    = diff_vec(p.b_start_x, p.b_start_y, p.b_start_z,
		                  p.a_start_x, p.a_start_y, p.a_start_z);
		normal = cross_wide(dir_a, dir_b);
		det    = dot_wide(normal, normal);
		r      = '0;
		if (det == 0) begin
			r.parallel = 1'b1;
			return r;
		end
		num_a    = dot_wide(cross_wide(gap, dir_b), normal);
		num_b    = dot_wide(cross_wide(gap, dir_a), normal);
		r.side_a = side_of_param(num_a, det);
		r.side_b = side_of_param(num_b, det);
		r.crossing = (r.side_a == SIDE_ON) && (r.side_b == SIDE_ON);
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_failure(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	always @(posedge clk) begin
		verdict_t want, got;
		if (arst_n) begin
			if (pair_ch.valid && pair_ch.ready)
				verdict_q.push_back(classify_pair({pair_ch.a_start_x, pair_ch.a_start_y,
					pair_ch.a_start_z, pair_ch.a_end_x, pair_ch.a_end_y, pair_ch.a_end_z,
					pair_ch.b_start_x, pair_ch.b_start_y, pair_ch.b_start_z,
					pair_ch.b_end_x, pair_ch.b_end_y, pair_ch.b_end_z}));
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.crossing, result_ch.parallel, result_ch.side_a,
				       result_ch.side_b};
				if (verdict_q.size() == 0) begin
					report_failure("result with no item outstanding");
				end else begin
					want = verdict_q.pop_front();
					if (got.crossing !== want.crossing)
						report_failure($sformatf("result %0d crossing: expected %0d, got %0b",
							checked_count, want.crossing, got.crossing));
					if (got.parallel !== want.parallel)
						report_failure($sformatf("result %0d parallel: expected %0d, got %0b",
							checked_count, want.parallel, got.parallel));
					if (got.side_a !== want.side_a)
						report_failure($sformatf("result %0d side_a: expected %0d, got %0b",
							checked_count, want.side_a, got.side_a));
					if (got.side_b !== want.side_b)
						report_failure($sformatf("result %0d side_b: expected %0d, got %0b",
							checked_count, want.side_b, got.side_b));
					if (want.crossing)
						crossing_count++;
					if (want.parallel)
						parallel_count++;
					checked_count++;
				end
			end
		end
	end

	// receiver stalls at random
	always @(negedge clk) begin
		result_ch.ready <= (int'($urandom_range(99)) >= rx_idle_pct);
	end

	// ---------------------------------------------------------------- stimulus

	function automatic seg_pair_t make_pair(input int ax, ay, az, aex, aey, aez,
	                                        input int bx, by, bz, bex, bey, bez);
		seg_pair_t p;
		p.a_start_x = coord_t'(ax);
		p.a_start_y = coord_t'(ay);
		p.a_start_z = coord_t'(az);
		p.a_end_x   = coord_t'(aex);
		p.a_end_y   = coord_t'(aey);
		p.a_end_z   = coord_t'(aez);
		p.b_start_x = coord_t'(bx);
		p.b_start_y = coord_t'(by);
		p.b_start_z = coord_t'(bz);
		p.b_end_x   = coord_t'(bex);
		p.b_end_y   = coord_t'(bey);
		p.b_end_z   = coord_t'(bez);
		return p;
	endfunction

	function automatic int rand_span(input int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_pair(input seg_pair_t p);
		while (int'($urandom_range(99)) < tx_idle_pct) begin
			pair_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pair_ch.valid     <= 1'b1;
		pair_ch.a_start_x <= p.a_start_x;
		pair_ch.a_start_y <= p.a_start_y;
		pair_ch.a_start_z <= p.a_start_z;
		pair_ch.a_end_x   <= p.a_end_x;
		pair_ch.a_end_y   <= p.a_end_y;
		pair_ch.a_end_z   <= p.a_end_z;
		pair_ch.b_start_x <= p.b_start_x;
		pair_ch.b_start_y <= p.b_start_y;
		pair_ch.b_start_z <= p.b_start_z;
		pair_ch.b_end_x   <= p.b_end_x;
		pair_ch.b_end_y   <= p.b_end_y;
		pair_ch.b_end_z   <= p.b_end_z;
		do
			@(posedge clk);
		while (!pair_ch.ready);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic test_extremes();
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767,
		                    32767, 32767, 32767, 32767, 32767, 32767));
		send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768,
		                    -32768, -32768, -32768, -32768, -32768, -32768));
		// main diagonals of the full cube cross near the center
		send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
		                    -32768, 32767, -32768, 32767, -32768, 32767));
		send_pair(make_pair(32767, -32768, 32767, -32768, 32767, -32768,
		                    -32768, -32768, 32767, 32767, 32767, -32768));
		send_pair(make_pair(32767, 0, -32768, -32768, 0, 32767,
		                    0, 32767, -32768, 0, -32768, 32767));
		send_pair(make_pair('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA,
		                    'hAAAA, 'hAAAA, 'h5555, 'h5555, 'h5555, 'hAAAA));
		send_pair(make_pair(-32768, 32767, 1, 32767, -32768, -1,
		                    -1, 1, -32768, 1, -1, 32767));
	endtask

	task automatic test_degenerate();
		// parallel distinct lines
		send_pair(make_pair(0, 0, 0, 1, 0, 0, 0, 1, 0, 2, 1, 0));
		// collinear, opposite directions
		send_pair(make_pair(-5, -5, -5, 5, 5, 5, 10, 10, 10, -10, -10, -10));
		// zero-length B, then zero-length A
		send_pair(make_pair(-10, 0, 0, 10, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(3, 4, 5, 3, 4, 5, 0, -10, 0, 0, 10, 0));
		send_pair(make_pair(-32768, 0, 0, 32767, 0, 0, -32768, 9, 9, 32767, 9, 9));
	endtask

	task automatic test_boundaries();
		send_pair(make_pair(-10, 0, 0, 10, 0, 0, 0, -10, 0, 0, 10, 0));
		// closest point exactly at the start: counts as before start
		send_pair(make_pair(0, 0, 0, 10, 0, 0, 0, -5, 0, 0, 5, 0));
		// closest point exactly at the end: still on the segment
		send_pair(make_pair(-10, 0, 0, 0, 0, 0, 0, -5, 0, 0, 5, 0));
		send_pair(make_pair(-10, 0, 0, -5, 0, 0, 0, -5, 0, 0, 5, 0));
		send_pair(make_pair(-10, 0, 0, 10, 0, 0, 0, 0, 0, 0, 7, 0));
		send_pair(make_pair(-10, 0, 0, 10, 0, 0, 0, -7, 0, 0, 0, 0));
		send_pair(make_pair(-10, 0, 0, 10, 0, 0, 0, 3, 0, 0, 8, 0));
		send_pair(make_pair(-10, 0, 0, 10, 0, 0, 0, -8, 0, 0, -3, 0));
	endtask

	task automatic test_skew_lines();
		// lines miss by a gap in z; in the first pair both parameters fall inside
		send_pair(make_pair(-10, 0, 0, 10, 0, 0, 0, -10, 5, 0, 10, 5));
		send_pair(make_pair(-10, 0, 0, 10, 0, 0, 30, -10, -7, 30, 10, -7));
		send_pair(make_pair(1, 2, 3, 4, 6, 11, -2, 9, 1, 7, -3, 5));
	endtask

	task automatic test_random_pairs(input int count);
		int        mode, span, ka, kb, m, off;
		int        px, py, pz, ux, uy, uz, vx, vy, vz, bx, by, bz;
		seg_pair_t p;
		repeat (count) begin
			mode = $urandom_range(99);
			span = ($urandom_range(3) == 0) ? 4 : 3000;
			px = rand_span(8000);
			py = rand_span(8000);
			pz = rand_span(8000);
			ux = rand_span(span);
			uy = rand_span(span);
			uz = rand_span(span);
			vx = rand_span(span);
			vy = rand_span(span);
			vz = rand_span(span);
			if (mode < 50) begin
				// lines through one point unless B is offset; parameters land on thirds, ends included
				ka  = $urandom_range(4);
				kb  = $urandom_range(4);
				off = ($urandom_range(1) == 0) ? 0 : rand_span(2);
				p = make_pair(px - ka * ux, py - ka * uy, pz - ka * uz,
				              px + (3 - ka) * ux, py + (3 - ka) * uy, pz + (3 - ka) * uz,
				              px - kb * vx + off, py - kb * vy, pz - kb * vz - off,
				              px + (3 - kb) * vx + off, py + (3 - kb) * vy,
				              pz + (3 - kb) * vz - off);
			end else if (mode < 65) begin
				// B runs along A, scaled; a zero scale collapses B
				m  = rand_span(3);
				bx = rand_span(8000);
				by = rand_span(8000);
				bz = rand_span(8000);
				if ($urandom_range(7) == 0) begin
					ux = 0;
					uy = 0;
					uz = 0;
				end
				p = make_pair(px, py, pz, px + ux, py + uy, pz + uz,
				              bx, by, bz, bx + m * ux, by + m * uy, bz + m * uz);
			end else if (mode < 80) begin
				p = make_pair(rand_span(4), rand_span(4), rand_span(4),
				              rand_span(4), rand_span(4), rand_span(4),
				              rand_span(4), rand_span(4), rand_span(4),
				              rand_span(4), rand_span(4), rand_span(4));
			end else begin
				p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			end
			send_pair(p);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[segment_crossing_test_3d] ERROR");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		result_ch.ready   = 1'b0;
		pair_ch.valid     = 1'b0;
		pair_ch.a_start_x = '0;
		pair_ch.a_start_y = '0;
		pair_ch.a_start_z = '0;
		pair_ch.a_end_x   = '0;
		pair_ch.a_end_y   = '0;
		pair_ch.a_end_z   = '0;
		pair_ch.b_start_x = '0;
		pair_ch.b_start_y = '0;
		pair_ch.b_start_z = '0;
		pair_ch.b_end_x   = '0;
		pair_ch.b_end_y   = '0;
		pair_ch.b_end_z   = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_idle_pct = 14;
		rx_idle_pct = 66;
		test_extremes();
		test_degenerate();
		test_boundaries();
		test_skew_lines();
		test_random_pairs(450);

		tx_idle_pct = 66;
		rx_idle_pct = 14;
		test_random_pairs(450);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_pairs(480);
		pair_ch.valid <= 1'b0;

		// drain, then watch for stray results
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (3 * LATENCY) @(posedge clk);

		$display("sent %0d segment pairs, checked %0d results in %0d cycles",
			sent_count, checked_count, cycle_count);
		$display("of those %0d crossing, %0d parallel or degenerate, %0d failures",
			crossing_count, parallel_count, error_count);
		if (error_count == 0)
			$display("[segment_crossing_test_3d] OK");
		else
			$display("[segment_crossing_test_3d] ERROR");
		$finish;
	end

endmodule
